### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define REBO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define REBO_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define REBO_ASSERT(lbl, clk, rstn, prop, msg)
`define REBO_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/rebo_pkg.sv
`timescale 1ns / 1ps

package rebo_pkg;

    localparam int REBO_DEPTH = 16;
    localparam int REF_W      = 32;
    localparam int LEN_W      = 16;
    localparam int OFS_W      = 20;

    typedef enum logic [0:0] {
        REQ_ADD  = 1'b0,
        REQ_FIND = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        req_kind_t          req_type;
        logic [REF_W-1:0]   entry_ref;
        logic [LEN_W-1:0]   entry_len;
        logic [OFS_W-1:0]   byte_offset;
    } rebo_req_t;

    typedef struct packed {
        logic               hit;
        logic [REF_W-1:0]   found_ref;
        logic [LEN_W-1:0]   found_len;
        logic [LEN_W-1:0]   pos_in_entry;
        logic               ring_full;
        logic               overwrote_oldest;
    } rebo_rsp_t;

endpackage

### rtl/rebo_req_if.sv
`timescale 1ns / 1ps

interface rebo_req_if
    import rebo_pkg::*;
();
    logic       valid;
    logic       ready;
    rebo_req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/rebo_rsp_if.sv
`timescale 1ns / 1ps

interface rebo_rsp_if
    import rebo_pkg::*;
();
    logic       valid;
    logic       ready;
    rebo_rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ring_entry_buffer_offset_lookup_core.sv
`timescale 1ns / 1ps

// channel | dir | payload     | beat when
// req     | in  | rebo_req_t  | req.valid && req.ready
// rsp     | out | rebo_rsp_t  | rsp.valid && rsp.ready
//
// add: writes the ram at its beat, then ST_DONE loads the result into the output register once that is free
// find: ST_WALK visits k entries oldest first, k = 0 .. DEPTH, up to a hit or the last valid one, then ST_DONE
// the single-port-read entry ram and the shared subtract/compare set the walk rate
// reset (async, rst_n low) empties the ring; no clearing pass is needed
// req.ready is high whenever the sequencer is idle, even while a result waits on rsp

`include "assert_macros.svh"

module ring_entry_buffer_offset_lookup_core
    import rebo_pkg::*;
#(
    parameter int DEPTH = REBO_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    rebo_req_if.sink     req,
    rebo_rsp_if.source   rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RAM_W = REF_W + LEN_W;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic               full_reg, full_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [PTR_W-1:0]   p_reg, p_next;
    logic [OFS_W-1:0]   rem_reg, rem_next;
    rebo_rsp_t          res_reg, res_next;
    rebo_rsp_t          out_data_reg, out_data_next;

    logic               req_acc;
    logic               out_free;
    logic               ram_we;
    logic [PTR_W-1:0]   ram_raddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;
    logic [LEN_W-1:0]   rd_len;
    logic [REF_W-1:0]   rd_ref;
    logic [CNT_W-1:0]   valid_cnt;
    logic [PTR_W-1:0]   wp_adv;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_acc    = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;

    assign ram_we     = req_acc && (req.data.req_type == REQ_ADD);
    assign ram_wdata  = {req.data.entry_ref, req.data.entry_len};
    // idle reads the oldest entry so a find starts comparing on its first walk cycle
    assign ram_raddr  = (state_reg == ST_IDLE) ? rp_reg : next_slot(p_reg);
    assign rd_len     = ram_rdata[LEN_W-1:0];
    assign rd_ref     = ram_rdata[RAM_W-1:LEN_W];
    assign wp_adv     = next_slot(wp_reg);

    always_comb
    begin
        if (full_reg)
        begin
            valid_cnt = CNT_W'(DEPTH);
        end
        else if (wp_reg >= rp_reg)
        begin
            valid_cnt = CNT_W'(wp_reg) - CNT_W'(rp_reg);
        end
        else
        begin
            valid_cnt = CNT_W'(wp_reg) + CNT_W'(DEPTH) - CNT_W'(rp_reg);
        end
    end

    rebo_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        full_next      = full_reg;
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    res_next = '0;
                    if (req.data.req_type == REQ_ADD)
                    begin
                        wp_next = wp_adv;
                        res_next.ring_full = full_reg;
                        if (full_reg)
                        begin
                            rp_next = next_slot(rp_reg);
                            res_next.overwrote_oldest = 1'b1;
                        end
                        else if (wp_adv == rp_reg)
                        begin
                            full_next = 1'b1;
                            res_next.ring_full = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        p_next   = rp_reg;
                        rem_next = req.data.byte_offset;
                        cnt_next = valid_cnt;
                        res_next.ring_full = full_reg;
                        // empty ring misses at once
                        if (valid_cnt == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                if (rem_reg < OFS_W'(rd_len))
                begin
                    res_next.hit          = 1'b1;
                    res_next.found_ref    = rd_ref;
                    res_next.found_len    = rd_len;
                    res_next.pos_in_entry = rem_reg[LEN_W-1:0];
                    state_next            = ST_DONE;
                end
                else
                begin
                    rem_next = rem_reg - OFS_W'(rd_len);
                    p_next   = next_slot(p_reg);
                    cnt_next = cnt_reg - CNT_W'(1);
                    // last valid entry passed without a match
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            full_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            full_reg      <= full_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    `REBO_ASSERT_IMPL(a_walk_cnt_nonzero, clk, rst_n, state_reg == ST_WALK, cnt_reg != '0, "walk with no entries left")
    `REBO_ASSERT_IMPL(a_full_ptrs_equal, clk, rst_n, full_reg, wp_reg == rp_reg, "full ring with pointers apart")
    `REBO_ASSERT_IMPL(a_hit_pos_in_len, clk, rst_n, rsp.valid && rsp.data.hit, rsp.data.pos_in_entry < rsp.data.found_len, "hit position beyond entry length")
    `REBO_ASSERT_IMPL(a_overwrite_full, clk, rst_n, rsp.valid && rsp.data.overwrote_oldest, rsp.data.ring_full && !rsp.data.hit, "overwrite reported on a ring that is not full")

endmodule

### rtl/rebo_ram.sv
`timescale 1ns / 1ps

module rebo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### bench/ring_entry_buffer_offset_lookup_core_tb.sv
`timescale 1ns / 1ps

module ring_entry_buffer_offset_lookup_core_tb;
    import rebo_pkg::*;

    localparam int PHASE_ITEMS = 282;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    rebo_req_if req_ch ();
    rebo_rsp_if rsp_ch ();

    ring_entry_buffer_offset_lookup_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor copy of the ring
    logic [REF_W-1:0] ring_ref [REBO_DEPTH];
    logic [LEN_W-1:0] ring_len [REBO_DEPTH];
    int               wr_slot;
    int               rd_slot;
    logic             ring_is_full;

    // lengths seen by the generator, oldest first, to aim find offsets
    int               stim_lens [$];

    rebo_req_t        req_backlog [$];
    rebo_rsp_t        rsp_expected [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_rsp;
    bit  req_taken;
    int  fail_cnt;
    int  n_add;
    int  n_find;
    int  n_hit;
    int  n_over;

    function automatic rebo_rsp_t predict_lookup(rebo_req_t r);
        rebo_rsp_t res;
        int        cnt;
        int        p;
        int        rem;
        res = '0;
        if (r.req_type == REQ_ADD)
        begin
            ring_ref[wr_slot] = r.entry_ref;
            ring_len[wr_slot] = r.entry_len;
            wr_slot = (wr_slot + 1) % REBO_DEPTH;
            if (ring_is_full)
            begin
                rd_slot = (rd_slot + 1) % REBO_DEPTH;
                res.overwrote_oldest = 1'b1;
            end
            else if (wr_slot == rd_slot)
            begin
                ring_is_full = 1'b1;
            end
        end
        else
        begin
            cnt = ring_is_full ? REBO_DEPTH : (wr_slot - rd_slot + REBO_DEPTH) % REBO_DEPTH;
            p   = rd_slot;
            rem = int'(r.byte_offset);
            for (int k = 0; k < cnt; k++)
            begin
                if (rem < int'(ring_len[p]))
                begin
                    res.hit          = 1'b1;
                    res.found_ref    = ring_ref[p];
                    res.found_len    = ring_len[p];
                    res.pos_in_entry = rem[LEN_W-1:0];
                    break;
                end
                rem -= int'(ring_len[p]);
                p = (p + 1) % REBO_DEPTH;
            end
        end
        res.ring_full = ring_is_full;
        return res;
    endfunction

    function automatic int stim_total();
        int sum;
        sum = 0;
        foreach (stim_lens[i])
            sum += stim_lens[i];
        return sum;
    endfunction

    task automatic push_add(logic [REF_W-1:0] eref, logic [LEN_W-1:0] elen);
        rebo_req_t r;
        r.req_type    = REQ_ADD;
        r.entry_ref   = eref;
        r.entry_len   = elen;
        r.byte_offset = OFS_W'($urandom);
        stim_lens.push_back(int'(elen));
        if (stim_lens.size() > REBO_DEPTH)
            void'(stim_lens.pop_front());
        req_backlog.push_back(r);
    endtask

    task automatic push_find(logic [OFS_W-1:0] ofs);
        rebo_req_t r;
        r.req_type    = REQ_FIND;
        r.entry_ref   = $urandom;
        r.entry_len   = LEN_W'($urandom);
        r.byte_offset = ofs;
        req_backlog.push_back(r);
    endtask

    task automatic push_random();
        int sel;
        int tot;
        logic [LEN_W-1:0] elen;
        sel = $urandom_range(0, 99);
        tot = stim_total();
        if (sel < 55 || stim_lens.size() == 0)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
                elen = '0;
            else if (sel < 70)
                elen = LEN_W'($urandom_range(1, 64));
            else if (sel < 90)
                elen = LEN_W'($urandom_range(65, 4095));
            else
                elen = LEN_W'($urandom_range(0, 65535));
            push_add($urandom, elen);
        end
        else
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70 && tot > 0)
                push_find(OFS_W'($urandom_range(0, tot - 1)));
            else if (sel < 85)
                push_find(OFS_W'(tot + $urandom_range(0, 3)));
            else
                push_find(OFS_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_ch.valid || rsp_expected.size() != 0)
            @(posedge clk);
    endtask

    // sender side and receiver ready, both moved on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_ch.data  <= req_backlog.pop_front();
                    req_ch.valid <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // predict on each request beat, check each result beat
    always @(posedge clk)
    begin
        rebo_rsp_t want;
        rebo_rsp_t got;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.data.req_type == REQ_ADD)
                    n_add++;
                else
                    n_find++;
                rsp_expected.push_back(predict_lookup(req_ch.data));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.data;
                if (rsp_expected.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: result with nothing expected: %p", $realtime, got);
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    if (want.overwrote_oldest)
                        n_over++;
                    if (want.hit)
                        n_hit++;
                    if (got.hit !== want.hit || got.found_ref !== want.found_ref ||
                        got.found_len !== want.found_len ||
                        got.pos_in_entry !== want.pos_in_entry ||
                        got.ring_full !== want.ring_full ||
                        got.overwrote_oldest !== want.overwrote_oldest)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("%0t: mismatch expected %p got %p", $realtime, want, got);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_rsp       = 1'b0;
        req_taken      = 1'b0;
        fail_cnt       = 0;
        n_add          = 0;
        n_find         = 0;
        n_hit          = 0;
        n_over         = 0;
        wr_slot        = 0;
        rd_slot        = 0;
        ring_is_full   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: find on empty ring, fill past full, then edge offsets
        push_find('0);
        push_add('0, 16'd1);
        push_add('1, '0);
        push_add(32'h5A5A_A5A5, '1);
        for (int i = 3; i < REBO_DEPTH; i++)
            push_add($urandom, LEN_W'($urandom_range(1, 40)));
        push_add(32'hC0DE_0001, 16'd7);
        push_find('0);
        push_find(OFS_W'(stim_total() / 2));
        push_find(OFS_W'(stim_total() - 1));
        push_find(OFS_W'(stim_total()));
        push_find('1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            // long receiver hold-off so the block backs up into the request side
            if (ph == 0)
            begin
                fork
                    begin
                        hold_rsp = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_rsp = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_random();
            wait_drained();
        end

        repeat (2 * REBO_DEPTH + 8) @(posedge clk);
        foreach (rsp_expected[i])
            fail_cnt++;
        $display("checked %0d beats (%0d adds, %0d finds): %0d hits, %0d overwrites",
                 n_add + n_find, n_add, n_find, n_hit, n_over);
        $display("handshake patterns: free-running, sparse sender, stalling receiver, mixed");
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
